@@ rtl/core/pctdec_pkg.sv @@
// ----------------------------------------------------------------------------
// pctdec_pkg
// Shared types, character constants and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package pctdec_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_PERCENT = 2'd1;
    localparam logic [1:0] PEND_DIGIT   = 2'd2;

    // Decoded work for one input item: up to three bytes, in order.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            fin;
    } pctdec_cmd_t;

    // Bit 4 set means a valid hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h41 + 8'd10)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/pctdec_front.sv @@
// ----------------------------------------------------------------------------
// pctdec_front
// Accepts raw bytes, tracks the pending escape and builds one command per
// item that lists the decoded bytes the item releases.
// ----------------------------------------------------------------------------
module pctdec_front
    import pctdec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_final,
    input  logic        q_full,
    output logic        cmd_push,
    output pctdec_cmd_t cmd
);

    logic [1:0] pend_count_reg;
    logic [1:0] pend_count_next;
    logic [7:0] pend_digit_reg;
    logic [7:0] pend_digit_next;
    logic [4:0] hex_cur;
    logic [4:0] hex_held;
    logic       do_idle;
    logic [1:0] base;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign hex_cur  = hex_decode(in_byte);
    assign hex_held = hex_decode(pend_digit_reg);

    always_comb
    begin
        pend_count_next = pend_count_reg;
        pend_digit_next = pend_digit_reg;
        cmd.bytes       = '0;
        cmd.fin         = in_final;
        do_idle         = 1'b0;
        base            = 2'd0;
        unique case (pend_count_reg)
            PEND_PERCENT:
            begin
                if (hex_cur[4] && !in_final)
                begin
                    pend_count_next = PEND_DIGIT;
                    pend_digit_next = in_byte;
                end
                else
                begin
                    cmd.bytes[0]    = CH_PERCENT;
                    base            = 2'd1;
                    pend_count_next = PEND_NONE;
                    do_idle         = 1'b1;
                end
            end
            PEND_DIGIT:
            begin
                pend_count_next = PEND_NONE;
                if (hex_cur[4])
                begin
                    cmd.bytes[0] = {hex_held[3:0], hex_cur[3:0]};
                    base         = 2'd1;
                end
                else
                begin
                    cmd.bytes[0] = CH_PERCENT;
                    cmd.bytes[1] = pend_digit_reg;
                    base         = 2'd2;
                    do_idle      = 1'b1;
                end
            end
            default:
            begin
                pend_count_next = PEND_NONE;
                do_idle         = 1'b1;
            end
        endcase
        cmd.count = base;
        if (do_idle)
        begin
            if (in_byte == CH_PERCENT && !in_final)
            begin
                pend_count_next = PEND_PERCENT;
            end
            else
            begin
                cmd.bytes[base] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
                cmd.count       = base + 2'd1;
            end
        end
        if (in_final)
        begin
            pend_count_next = PEND_NONE;
        end
    end

    assign cmd_push = accept && (cmd.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_count_reg <= PEND_NONE;
            pend_digit_reg <= 8'd0;
        end
        else if (accept)
        begin
            pend_count_reg <= pend_count_next;
            pend_digit_reg <= pend_digit_next;
        end
    end

endmodule

@@ rtl/core/pctdec_queue.sv @@
// ----------------------------------------------------------------------------
// pctdec_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pctdec_queue
    import pctdec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pctdec_cmd_t push_cmd,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output pctdec_cmd_t head_cmd
);

    pctdec_cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

@@ rtl/core/pctdec_back.sv @@
// ----------------------------------------------------------------------------
// pctdec_back
// Walks the head command one byte per transfer and marks run and string ends.
// ----------------------------------------------------------------------------
module pctdec_back
    import pctdec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  pctdec_cmd_t head_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_run_last,
    output logic        out_string_last
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       xfer;

    assign out_valid       = !q_empty;
    assign out_byte        = head_cmd.bytes[idx_reg];
    assign out_run_last    = (idx_reg == head_cmd.count - 2'd1);
    assign out_string_last = out_run_last && head_cmd.fin;
    assign xfer            = out_valid && out_ready;
    assign q_pop           = xfer && out_run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = out_run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ rtl/core/percent_decoder.sv @@
// ----------------------------------------------------------------------------
// percent_decoder
// Streaming URL percent decoder with plus as space.
//
// Input channel (in_valid/in_ready): one raw byte per transfer, in_final
// on the last byte of a string. Output channel (out_valid/out_ready): one
// decoded byte per transfer; out_run_last closes the bytes one input caused,
// out_string_last marks the last decoded byte of the string.
// An input can release zero to three bytes. The front decodes the byte in
// the cycle it is accepted and, if bytes are released, registers a command
// in a two-entry queue for the back. The back drains a command at one byte
// per cycle while out_ready is high, so k released bytes take k transfers.
// Input rate is one byte per cycle while the queue has room; sustained rate
// is set by the back's one-byte-per-cycle port. A stalled receiver fills
// the queue, then in_ready drops.
// Reset clears the pending escape state and empties the queue.
// ----------------------------------------------------------------------------
module percent_decoder
    import pctdec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_final,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_run_last,
    output logic       out_string_last
);

    pctdec_cmd_t push_cmd;
    pctdec_cmd_t head_cmd;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;

    pctdec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_final (in_final),
        .q_full   (full),
        .cmd_push (push),
        .cmd      (push_cmd)
    );

    pctdec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_cmd (head_cmd)
    );

    pctdec_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (empty),
        .head_cmd        (head_cmd),
        .q_pop           (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .out_run_last    (out_run_last),
        .out_string_last (out_string_last)
    );

endmodule

@@ rtl/core/pctdec_checker.sv @@
// ----------------------------------------------------------------------------
// pctdec_checker
// Port-level checks for the percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pctdec_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       in_final,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_run_last,
    input logic       out_string_last
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_final))
        else $error("input transfer dropped or changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte))
        else $error("out_byte changed while stalled");

    a_string_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_string_last |-> out_run_last)
        else $error("string end outside a run end");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_run_last |=> out_valid)
        else $error("run broken before its last byte");

endmodule

bind percent_decoder pctdec_checker u_pctdec_checker (.*);
